### hw/rtl/tcmm_pkg.sv
// Package for the tree cell moment merge block: command codes, FSM state type,
// controller/datapath command and status structs. No dependencies.
package tcmm_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEOM = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DIV   = 10'b0000000010,
    ST_DNEXT = 10'b0000000100,
    ST_DIFF  = 10'b0000001000,
    ST_SQ    = 10'b0000010000,
    ST_SUM   = 10'b0000100000,
    ST_SQRT  = 10'b0001000000,
    ST_ACC   = 10'b0010000000,
    ST_OUT   = 10'b0100000000,
    ST_LOAD  = 10'b1000000000
  } tcmm_state_t;

  typedef struct packed {
    logic       load;       // accept a daughter into the accumulators
    logic       geom;       // latch geometry, prepare division
    logic       div_start;  // start divider on axis div_axis
    logic [1:0] div_axis;
    logic       div_step;
    logic       div_end;    // store quotient for div_axis
    logic       dist_diff;  // form component distances for current point
    logic       dist_sq;
    logic       dist_sum;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       dist_acc;   // fold root into bound
    logic       pt_next;    // advance to next point
    logic       out_load;
    logic       clear;
  } tcmm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic zero;
    logic last_pt;   // current point is the corner
  } tcmm_sts_t;

endpackage

### hw/rtl/tcmm_ctrl.sv
// Controller FSM for the tree cell moment merge block.
// Depends on tcmm_pkg.
module tcmm_ctrl
  import tcmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_cmd,
  input  logic       out_busy,
  input  tcmm_sts_t  sts,
  output logic       in_ready,
  output tcmm_cmd_t  cmd
);

  tcmm_state_t state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.div_axis = axis_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_cmd == CMD_GEOM) begin
            cmd.geom  = 1'b1;
            axis_nxt  = 2'd0;
            state_nxt = ST_DNEXT;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_DNEXT: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_end = 1'b1;
          if (axis_r == 2'd2) state_nxt = ST_DIFF;
          else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_DNEXT;
          end
        end
      end
      ST_DIFF: begin
        cmd.dist_diff = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.dist_sq = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.dist_sum   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.dist_acc = 1'b1;
        if (sts.last_pt) state_nxt = ST_OUT;
        else begin
          cmd.pt_next = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/tcmm_dp.sv
// Datapath for the tree cell moment merge block: accumulators, daughter
// store, serial divider, distance unit and serial square root. Uses tcmm_pkg.
module tcmm_dp
  import tcmm_pkg::*;
#(
  parameter int MAX_CHILDREN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcmm_cmd_t          cmd,
  input  logic               is_subcell,
  input  logic [31:0]        mass,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        extent,
  input  logic [30:0]        radius_bound,
  input  logic [15:0]        sub_count,
  output tcmm_sts_t          sts,
  output logic [31:0]        res_mass,
  output logic signed [31:0] res_cx,
  output logic signed [31:0] res_cy,
  output logic signed [31:0] res_cz,
  output logic [30:0]        res_bound,
  output logic [30:0]        res_extent,
  output logic [15:0]        res_count,
  output logic [30:0]        res_size
);

  localparam int FW = $clog2(MAX_CHILDREN + 1);
  localparam int IW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // daughter store
  logic signed [31:0] st_px [MAX_CHILDREN];
  logic signed [31:0] st_py [MAX_CHILDREN];
  logic signed [31:0] st_pz [MAX_CHILDREN];
  logic [30:0]        st_b  [MAX_CHILDREN];

  logic [FW-1:0]      fill_r;
  logic [31:0]        msum_r;
  logic signed [63:0] wsum_r [3];
  logic [30:0]        emax_r;
  logic [15:0]        cnt_r;

  logic               full;
  logic [32:0]        msum_w;
  logic [16:0]        cnt_w;
  logic signed [63:0] prod [3];
  logic signed [64:0] wadd [3];
  logic signed [31:0] pin [3];

  assign pin[0] = pos_x;
  assign pin[1] = pos_y;
  assign pin[2] = pos_z;
  assign full   = (fill_r >= FW'(MAX_CHILDREN));
  assign msum_w = {1'b0, msum_r} + {1'b0, mass};
  assign cnt_w  = {1'b0, cnt_r} + (is_subcell ? {1'b0, sub_count} : 17'd1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = $signed({1'b0, mass}) * pin[k];
      wadd[k] = {wsum_r[k][63], wsum_r[k]} + {prod[k][63], prod[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      st_px[fill_r[IW-1:0]] <= pos_x;
      st_py[fill_r[IW-1:0]] <= pos_y;
      st_pz[fill_r[IW-1:0]] <= pos_z;
      st_b[fill_r[IW-1:0]]  <= is_subcell ? radius_bound : 31'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      fill_r <= '0;
      msum_r <= '0;
      emax_r <= '0;
      cnt_r  <= '0;
      for (int k = 0; k < 3; k++) wsum_r[k] <= '0;
    end else if (cmd.load && !full) begin
      fill_r <= fill_r + FW'(1);
      msum_r <= msum_w[32] ? 32'hFFFF_FFFF : msum_w[31:0];
      if (extent > emax_r) emax_r <= extent;
      cnt_r  <= cnt_w[16] ? 16'hFFFF : cnt_w[15:0];
      for (int k = 0; k < 3; k++) begin
        if (wadd[k][64] != wadd[k][63]) wsum_r[k] <= wadd[k][64] ? S64_MIN : S64_MAX;
        else wsum_r[k] <= wadd[k][63:0];
      end
    end
  end

  // geometry latch
  logic signed [31:0] gp_r [3];
  logic [30:0]        size_r;
  logic               zero_r;
  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      gp_r[0] <= pos_x;
      gp_r[1] <= pos_y;
      gp_r[2] <= pos_z;
      size_r  <= extent;
      zero_r  <= (msum_r == 32'd0);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [63:0]        dnum_r;
  logic [32:0]        drem_r;
  logic [6:0]         dcnt_r;
  logic               dneg_r;
  logic signed [31:0] cm_r [3];
  logic [63:0]        wmag;
  logic [32:0]        dtry;
  logic [33:0]        dsub;
  logic signed [63:0] wsel;

  assign wsel = wsum_r[cmd.div_axis];
  assign wmag = wsel[63] ? (64'd0 - wsel) : wsel;
  assign dtry = {drem_r[31:0], dnum_r[63]};
  assign dsub = {1'b0, dtry} - {2'b0, msum_r};
  assign sts.div_done = (dcnt_r == 7'd63);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum_r <= wmag;
      drem_r <= '0;
      dcnt_r <= '0;
      dneg_r <= wsel[63];
    end else if (cmd.div_step) begin
      drem_r <= dsub[33] ? dtry : dsub[32:0];
      dnum_r <= {dnum_r[62:0], ~dsub[33]};
      dcnt_r <= dcnt_r + 7'd1;
    end
  end

  // final quotient bit folded in at div_end
  logic [63:0] q_fin;
  assign q_fin = {dnum_r[62:0], ~dsub[33]};
  always_ff @(posedge clk) begin
    if (cmd.div_end) begin
      if (zero_r) cm_r[cmd.div_axis] <= '0;
      else if (dneg_r)
        cm_r[cmd.div_axis] <= (q_fin > 64'h8000_0000) ? 32'sh8000_0000
                                                    : 32'(64'd0 - q_fin);
      else
        cm_r[cmd.div_axis] <= (q_fin > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_fin);
    end
  end

  // distance unit: points are daughters 0..fill-1, then the corner
  logic [FW-1:0] pt_r;
  logic [32:0]   dd_r [3];
  logic [63:0]   sq_r [3];
  logic [63:0]   ss_r;
  logic [30:0]   bmax_r;
  logic          corner;
  logic [30:0]   half;
  logic signed [33:0] ta [3];
  logic signed [33:0] tb [3];
  logic signed [33:0] tdf [3];
  logic [31:0]   cc [3];
  logic [64:0]   s01;
  logic [64:0]   s012;

  assign corner      = (pt_r == fill_r);
  assign sts.last_pt = corner;
  assign sts.zero    = zero_r;
  assign half        = {1'b0, size_r[30:1]};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ta[k] = 34'(cm_r[k]);
      tb[k] = '0;
      tdf[k] = '0;
    end
    if (corner) begin
      for (int k = 0; k < 3; k++) begin
        tb[k]  = 34'(gp_r[k]) + 34'($signed({1'b0, half}));
      end
    end else begin
      tb[0] = 34'(st_px[pt_r[IW-1:0]]);
      tb[1] = 34'(st_py[pt_r[IW-1:0]]);
      tb[2] = 34'(st_pz[pt_r[IW-1:0]]);
    end
    for (int k = 0; k < 3; k++) begin
      tdf[k] = (ta[k] >= tb[k]) ? ta[k] - tb[k] : tb[k] - ta[k];
    end
    for (int k = 0; k < 3; k++) cc[k] = dd_r[k][32] ? 32'hFFFF_FFFF : dd_r[k][31:0];
    s01  = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    s012 = {1'b0, (s01[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s01[63:0])} + {1'b0, sq_r[2]};
  end

  // square root: two radicand bits per cycle
  logic [63:0] rv_r, rres_r;
  logic [63:0] rbit_r;
  logic [63:0] rtry;
  assign rtry = rres_r + rbit_r;
  assign sts.sqrt_done = (rbit_r == 64'd0);

  // daughter bound plus root, wide enough that it never wraps
  logic [32:0] nbsum;
  always_comb nbsum = {2'b0, (corner ? 31'd0 : st_b[pt_r[IW-1:0]])} + {1'b0, rres_r[31:0]};

  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      pt_r   <= '0;
      bmax_r <= '0;
    end
    if (cmd.dist_diff) begin
      for (int k = 0; k < 3; k++)
        dd_r[k] <= corner ? 33'(tdf[k]) + {2'b0, half} : tdf[k][32:0];
    end
    if (cmd.dist_sq) begin
      for (int k = 0; k < 3; k++) sq_r[k] <= cc[k] * cc[k];
    end
    if (cmd.dist_sum) ss_r <= s012[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s012[63:0];
    if (cmd.sqrt_start) begin
      rv_r   <= ss_r;
      rres_r <= '0;
      rbit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step && !sts.sqrt_done) begin
      if (rv_r >= rtry) begin
        rv_r   <= rv_r - rtry;
        rres_r <= (rres_r >> 1) + rbit_r;
      end else begin
        rres_r <= rres_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
    end
    if (cmd.dist_acc) begin
      if (corner) begin
        if (rres_r < {33'd0, bmax_r}) bmax_r <= rres_r[30:0];
      end else if (nbsum[32:31] != 2'b00 || rres_r[63:32] != 32'd0) begin
        bmax_r <= 31'h7FFF_FFFF;
      end else if (nbsum[30:0] > bmax_r) begin
        bmax_r <= nbsum[30:0];
      end
    end
    if (cmd.pt_next) pt_r <= pt_r + FW'(1);
  end

  assign res_mass   = msum_r;
  assign res_cx     = cm_r[0];
  assign res_cy     = cm_r[1];
  assign res_cz     = cm_r[2];
  assign res_bound  = bmax_r;
  assign res_extent = emax_r;
  assign res_count  = cnt_r;
  assign res_size   = size_r;

endmodule

### hw/rtl/tree_cell_moment_merge.sv
// Top level of the tree cell moment merge block: stream ports, output register.
// Depends on tcmm_pkg, tcmm_ctrl, tcmm_dp.
//
// Usage: stream daughters in on the in_ channel with in_tuser[0] (command) = 0,
// in_tuser[1] = is_subcell. Load transactions are taken while the block is
// idle; loads past MAX_CHILDREN are dropped. A transaction with command = 1
// carries the cell corner in pos_x/y/z and the cell size in extent, and
// starts the finish pass. Finish pass: three serial 64-bit divides (one
// quotient bit per cycle), then for each daughter plus the far corner a
// distance pass (difference, square, sum, root load, a 32-step square root
// plus its done check, and accumulate); in_tready is low during the finish
// pass. The summary lands in an output register and is held on out_tdata/
// out_tuser while out_tready is low; a stalled result holds the controller
// before clear, so nothing is lost. Reset (rst_n low, synchronous) empties
// the cell and the output register.
module tree_cell_moment_merge
  import tcmm_pkg::*;
#(
  parameter int MAX_CHILDREN = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mass[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96], extent[158:128],
  // radius_bound[189:159], sub_count[205:190], zero pad to 208
  input  logic [207:0] in_tdata,
  // command[0], is_subcell[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // total_mass[31:0], center_x[63:32], center_y[95:64], center_z[127:96],
  // bound_radius[158:128], max_extent[189:159], body_count[205:190],
  // cell_size[236:206], zero pad to 240
  output logic [239:0] out_tdata,
  // zero_mass[0]
  output logic         out_tuser
);

  tcmm_cmd_t cmd;
  tcmm_sts_t sts;
  logic      in_fire;
  logic      out_vld_r;
  logic [239:0] out_data_r;
  logic      out_zero_r;

  logic [31:0] r_mass;
  logic signed [31:0] r_cx, r_cy, r_cz;
  logic [30:0] r_bound, r_ext, r_size;
  logic [15:0] r_cnt;

  assign in_fire = in_tvalid && in_tready;

  tcmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (in_tuser[0]),
    .out_busy (out_vld_r && !out_tready),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  tcmm_dp #(.MAX_CHILDREN(MAX_CHILDREN)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .is_subcell   (in_tuser[1]),
    .mass         (in_tdata[31:0]),
    .pos_x        (in_tdata[63:32]),
    .pos_y        (in_tdata[95:64]),
    .pos_z        (in_tdata[127:96]),
    .extent       (in_tdata[158:128]),
    .radius_bound (in_tdata[189:159]),
    .sub_count    (in_tdata[205:190]),
    .sts          (sts),
    .res_mass     (r_mass),
    .res_cx       (r_cx),
    .res_cy       (r_cy),
    .res_cz       (r_cz),
    .res_bound    (r_bound),
    .res_extent   (r_ext),
    .res_count    (r_cnt),
    .res_size     (r_size)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (cmd.out_load) out_vld_r <= 1'b1;
    else if (out_tready) out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'd0, r_size, r_cnt, r_ext, r_bound, r_cz, r_cy, r_cx, r_mass};
      out_zero_r <= sts.zero;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  // a new result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_vld_r && !out_tready))
    else $error("result overwritten");

  // input is never taken while the finish pass runs
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.sqrt_step) |-> !in_tready)
    else $error("input taken during finish");

  // zero mass result carries a zero center
  a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[127:32] == 96'd0))
    else $error("zero mass with nonzero center");

endmodule

### bench/tree_cell_moment_merge_tb.sv
// Testbench for tree_cell_moment_merge: drives daughter loads and geometry
// transactions, predicts each cell summary, checks results in order.
// Depends on tcmm_pkg and the tree_cell_moment_merge RTL.

// Expected cell summary, one per geometry transaction.
typedef struct {
  logic [31:0] total_mass;
  logic [31:0] cx, cy, cz;
  logic [30:0] bound_radius;
  logic [30:0] max_extent;
  logic [15:0] body_count;
  logic [30:0] cell_size;
  logic        zero_mass;
} summary_t;

class cell_summary_board;
  // predictor state: one cell under construction
  longint      pos_mem[8][3];
  longint      bnd_mem[8];
  int          fill;
  longint      mass_acc;
  longint      wsum[3];
  longint      ext_max;
  longint      cnt_acc;
  summary_t    pending[$];
  int          errors;

  function new();
    errors = 0;
    clear_cell();
  endfunction

  function void clear_cell();
    fill = 0;
    mass_acc = 0;
    ext_max = 0;
    cnt_acc = 0;
    for (int k = 0; k < 3; k++) wsum[k] = 0;
  endfunction

  // floor integer square root of a 64-bit unsigned value
  function logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic [63:0] mag_sq(logic [63:0] d[3]);
    logic [63:0] s, c;
    logic [64:0] t;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      c = (d[k] > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d[k];
      t = {1'b0, s} + {1'b0, c * c};
      s = t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
    end
    return s;
  endfunction

  function logic [63:0] adiff(longint a, longint b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  // note one accepted input transaction
  function void note_input(logic [207:0] data, logic [1:0] user);
    logic [31:0] mass;
    longint      p[3];
    longint      ext, rb, cnt, prod, s;
    longint      cm[3];
    logic [63:0] d[3];
    logic [63:0] bmax, nb, half, cb, mag, q;
    summary_t    e;
    mass = data[31:0];
    p[0] = longint'($signed(data[63:32]));
    p[1] = longint'($signed(data[95:64]));
    p[2] = longint'($signed(data[127:96]));
    ext  = data[158:128];
    rb   = data[189:159];
    cnt  = data[205:190];
    if (user[0] == tcmm_pkg::CMD_LOAD) begin
      if (fill >= 8) return;  // cell full, transaction dropped
      for (int k = 0; k < 3; k++) begin
        pos_mem[fill][k] = p[k];
        prod = longint'(mass) * p[k];  // fits: 32-bit unsigned times 32-bit signed
        s = wsum[k] + prod;
        if (prod > 0 && wsum[k] > 0 && s < 0) s = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (prod < 0 && wsum[k] < 0 && s >= 0) s = 64'sh8000_0000_0000_0000;
        wsum[k] = s;
      end
      bnd_mem[fill] = user[1] ? rb : 0;
      fill++;
      mass_acc = mass_acc + mass;
      if (mass_acc > 64'hFFFF_FFFF) mass_acc = 64'hFFFF_FFFF;
      if (ext > ext_max) ext_max = ext;
      cnt_acc = cnt_acc + (user[1] ? cnt : 1);
      if (cnt_acc > 65535) cnt_acc = 65535;
      return;
    end
    e.zero_mass = (mass_acc == 0);
    for (int k = 0; k < 3; k++) begin
      cm[k] = 0;
      if (!e.zero_mass) begin
        mag = (wsum[k] < 0) ? 64'(-wsum[k]) : 64'(wsum[k]);
        q = mag / 64'(mass_acc);
        if (wsum[k] < 0) cm[k] = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
        else cm[k] = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
      end
    end
    bmax = 0;
    for (int i = 0; i < fill; i++) begin
      for (int k = 0; k < 3; k++) d[k] = adiff(cm[k], pos_mem[i][k]);
      nb = 64'(bnd_mem[i]) + root64(mag_sq(d));
      if (nb > 64'h7FFF_FFFF) nb = 64'h7FFF_FFFF;
      if (nb > bmax) bmax = nb;
    end
    half = 64'(ext >> 1);
    for (int k = 0; k < 3; k++) d[k] = half + adiff(cm[k], p[k] + longint'(half));
    cb = root64(mag_sq(d));
    if (cb < bmax) bmax = cb;
    e.total_mass   = mass_acc[31:0];
    e.cx           = cm[0][31:0];
    e.cy           = cm[1][31:0];
    e.cz           = cm[2][31:0];
    e.bound_radius = bmax[30:0];
    e.max_extent   = ext_max[30:0];
    e.body_count   = cnt_acc[15:0];
    e.cell_size    = ext[30:0];
    pending.push_back(e);
    clear_cell();
  endfunction

  function void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h actual %h", name, want, got);
      errors++;
    end
  endfunction

  // check one accepted result against the oldest expectation
  function void check_result(logic [239:0] data, logic user);
    summary_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction: data %h", data);
      errors++;
      return;
    end
    e = pending.pop_front();
    cmp("total_mass", e.total_mass, data[31:0]);
    cmp("center_x", e.cx, data[63:32]);
    cmp("center_y", e.cy, data[95:64]);
    cmp("center_z", e.cz, data[127:96]);
    cmp("bound_radius", 32'(e.bound_radius), 32'(data[158:128]));
    cmp("max_extent", 32'(e.max_extent), 32'(data[189:159]));
    cmp("body_count", 32'(e.body_count), 32'(data[205:190]));
    cmp("cell_size", 32'(e.cell_size), 32'(data[236:206]));
    cmp("zero_mass", 32'(e.zero_mass), 32'(user));
  endfunction
endclass

module tree_cell_moment_merge_tb;
  import tcmm_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [207:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [239:0] out_tdata;
  logic         out_tuser;

  cell_summary_board board;
  int           cycle_count;
  bit           stim_done;
  bit           hold_off;     // short random receiver stall
  bit           long_hold;    // long receiver stall for the pressure phase
  int           results_seen;

  localparam int CYCLE_LIMIT = 1500000;

  tree_cell_moment_merge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // gap length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // random 32-bit value biased toward the edges of the range
  function automatic logic [31:0] edgy32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 255);
      5: return {{16{1'($urandom_range(0, 1))}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one input transaction at the falling edge, held until accepted;
  // blocking writes so back-to-back calls can retire and re-arm valid
  task automatic send(logic cmd, logic sub, logic [31:0] m, logic [31:0] x,
                      logic [31:0] y, logic [31:0] z, logic [30:0] ext,
                      logic [30:0] rb, logic [15:0] cnt);
    in_tdata  = {2'b00, cnt, rb, ext, z, y, x, m};
    in_tuser  = {sub, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_input({2'b00, cnt, rb, ext, z, y, x, m}, {sub, cmd});
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic idle_gap();
    int g;
    g = pick_gap();
    repeat (g) @(negedge clk);
  endtask

  // random daughter; narrow values on most so the arithmetic is non-trivial
  task automatic send_daughter(bit noisy);
    logic [31:0] m, x, y, z;
    if (noisy) begin
      m = edgy32(); x = edgy32(); y = edgy32(); z = edgy32();
    end else begin
      m = $urandom_range(0, 32'h0010_0000);
      x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      z = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    end
    send(CMD_LOAD, 1'($urandom_range(0, 1)), m, x, y, z, 31'($urandom),
         31'(noisy ? $urandom : $urandom_range(0, 32'h0010_0000)), 16'($urandom));
  endtask

  task automatic send_geom(bit noisy);
    send(CMD_GEOM, 1'($urandom_range(0, 1)), $urandom,
         noisy ? edgy32() : 32'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000),
         noisy ? edgy32() : 32'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000),
         noisy ? edgy32() : 32'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000),
         31'(noisy ? $urandom : $urandom_range(0, 32'h0100_0000)),
         31'($urandom), 16'($urandom));
  endtask

  // receiver: random stalls, plus long hold-offs when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off || long_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 9) == 0);
    end
  end

  // extra random stall stretches on the receiver
  initial begin
    int g;
    hold_off = 1'b0;
    @(posedge rst_n);
    forever begin
      g = pick_gap();
      repeat (g * 4 + 10) @(negedge clk);
      if ($urandom_range(0, 9) == 0) begin
        hold_off = 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
        hold_off = 1'b0;
      end
    end
  end

  // sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser);
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n_items, nd;
    board = new();
    cycle_count = 0;
    results_seen = 0;
    stim_done = 0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cell
    send(CMD_GEOM, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 16'h0);
    // zero mass daughters still give bounds against a zero center
    send(CMD_LOAD, 1'b1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 31'h7FFF_FFFF,
         31'h7FFF_FFFF, 16'hFFFF);
    send(CMD_LOAD, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 31'h0, 31'h0, 16'h0);
    send(CMD_GEOM, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
         31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    // full cell plus overflow loads, saturating mass and counts
    for (int i = 0; i < 10; i++)
      send(CMD_LOAD, 1'b1, 32'hFFFF_FFFF, (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 31'(i * 1000), 31'h7FFF_FFFF, 16'hFFFF);
    send(CMD_GEOM, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0001_0000, 31'h0, 16'h0);
    // single body, small cell
    send(CMD_LOAD, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0,
         31'h0000_8000, 31'h0, 16'h0);
    send(CMD_GEOM, 1'b0, 32'h0, 32'h0, 32'hFFFE_0000, 32'hFFFF_0000, 31'h1, 31'h0, 16'h0);

    // pressure: hold the receiver off while cells keep coming
    long_hold = 1'b1;
    fork
      begin
        for (int c = 0; c < 3; c++) begin
          send_daughter(0);
          send_geom(0);
        end
      end
      begin
        repeat (3000) @(negedge clk);
        long_hold = 1'b0;
      end
    join

    // random cells
    n_items = 0;
    while (n_items < 850) begin
      nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 8);
      for (int i = 0; i < nd; i++) begin
        send_daughter($urandom_range(0, 4) == 0);
        n_items++;
        idle_gap();
      end
      send_geom($urandom_range(0, 4) == 0);
      n_items++;
      idle_gap();
    end
    stim_done = 1;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
